[hdl/mip_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_pkg
// Shared types and constants for the MIDI input parser: parse phases,
// result kinds, register indexes, the configuration set and the result beat.
// ----------------------------------------------------------------------------
package mip_pkg;

    localparam int SX_LEN_W = 13;
    localparam logic [SX_LEN_W-1:0] MAX_SYSEX = 13'd4096;

    // Parser phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ONE_OF_ONE,
        PH_ONE_OF_TWO,
        PH_SECOND,
        PH_SYSEX
    } t_phase;

    // Result kinds
    localparam logic [1:0] KIND_CHAN      = 2'd0;
    localparam logic [1:0] KIND_RT        = 2'd1;
    localparam logic [1:0] KIND_NATIVE    = 2'd2;
    localparam logic [1:0] KIND_UNIVERSAL = 2'd3;

    // Register indexes
    localparam logic [1:0] CFG_MANUFACTURER = 2'd0;
    localparam logic [1:0] CFG_PRODUCT      = 2'd1;
    localparam logic [1:0] CFG_DEVICE       = 2'd2;
    localparam logic [1:0] CFG_CLOCK_WRAP   = 2'd3;

    // Byte codes
    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] SYSEX_END    = 8'hF7;
    localparam logic [7:0] RT_FIRST     = 8'hF8;
    localparam logic [3:0] SYS_NIBBLE   = 4'hF;
    localparam logic [3:0] PGM_NIBBLE   = 4'hC;
    localparam logic [3:0] PRESS_NIBBLE = 4'hD;
    localparam logic [3:0] RT_CLOCK     = 4'h8;
    localparam logic [3:0] RT_START     = 4'hA;
    localparam logic [6:0] UNIVERSAL_NRT = 7'h7E;
    localparam logic [6:0] BROADCAST_ID  = 7'h7F;

    typedef struct packed {
        logic [23:0] manufacturer_id;
        logic [6:0]  product_id;
        logic [6:0]  device_id;
        logic [15:0] clock_wrap;
    } t_cfg;

    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          status;
        logic [3:0]          channel;
        logic [6:0]          data_first;
        logic [6:0]          data_second;
        logic [6:0]          sysex_command;
        logic [SX_LEN_W-1:0] sysex_length;
        logic [15:0]         clock_position;
    } t_result;

endpackage

[hdl/midi_input_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_input_parser
// MIDI byte stream parser: running-status channel messages, real-time bytes
// with song clock position, and sysex capture with native/universal class.
// ----------------------------------------------------------------------------
// Pipeline: an accepted byte is held in the input register, and its result beat
//   is then loaded into the result register for the master side.
// Throughput: one byte per cycle unless a result beat waits on the master side;
//   the parse step is a single pass of logic between the two registers.
// Reset (synchronous, active low): parser idle, no running status, clock
//   disarmed at position zero, registers at their defaults, both stages empty.
module midi_input_parser
    import mip_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] status, [11:8] channel, [18:12] data_first, [25:19] data_second,
    // [32:26] sysex_command, [45:33] sysex_length, [61:46] clock_position
    output logic [63:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       adv;
    logic       emit;
    t_result    result;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.manufacturer_id <= 24'h002127;
            r_cfg.product_id      <= 7'h5D;
            r_cfg.device_id       <= 7'h00;
            r_cfg.clock_wrap      <= 16'd384;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MANUFACTURER: r_cfg.manufacturer_id <= i_cfg_data;
                CFG_PRODUCT:      r_cfg.product_id      <= i_cfg_data[6:0];
                CFG_DEVICE:       r_cfg.device_id       <= i_cfg_data[6:0];
                CFG_CLOCK_WRAP:   r_cfg.clock_wrap      <= i_cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    mip_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_emit   (emit),
        .o_result (result)
    );

    // Load a new beat on advance; otherwise drop the beat once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {2'b00, r_out.clock_position, r_out.sysex_length,
                            r_out.sysex_command, r_out.data_second,
                            r_out.data_first, r_out.channel, r_out.status};

    a_rt_always_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && (r_in_byte >= RT_FIRST) |=> r_out_valid && (r_out.kind == KIND_RT))
        else $error("real-time byte did not produce a beat");

    a_sys_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind != KIND_CHAN) |-> r_out.status == SYSEX_START)
        else $error("system beat with wrong status");

    a_chan_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind == KIND_CHAN)
        |-> r_out.status[7] && (r_out.status != SYSEX_START) && (r_out.sysex_length == '0))
        else $error("channel beat with bad status or length");

endmodule

[hdl/mip_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_parser
// Byte-wise parse state: running status, sysex capture and song clock.
// Computes the result of one byte combinationally and updates state on i_en.
// ----------------------------------------------------------------------------
module mip_parser
    import mip_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output logic       o_emit,
    output t_result    o_result
);

    localparam logic [SX_LEN_W-1:0] SX_HDR_LAST = 13'd6;

    t_phase              r_phase, n_phase;
    logic [3:0]          r_run_status, n_run_status;
    logic [3:0]          r_run_chan, n_run_chan;
    logic [6:0]          r_held, n_held;
    logic [SX_LEN_W-1:0] r_sx_count, n_sx_count;
    logic [6:0]          r_sx_hdr [6];
    logic                r_armed, n_armed;
    logic [15:0]         r_clk_count, n_clk_count;

    logic                is_rt;
    logic                is_status;
    logic                is_sx_end;
    logic [3:0]          hi;
    logic                run_one_byte;
    logic                hi_one_byte;
    logic [16:0]         clk_sum;
    logic [SX_LEN_W-1:0] sx_count_inc;
    logic                hdr_we;
    logic [2:0]          hdr_idx;
    logic                mfg_match;
    logic                native_ok;
    logic                universal_ok;

    assign hi           = i_byte[7:4];
    assign is_rt        = (i_byte >= RT_FIRST);
    assign is_status    = i_byte[7];
    assign is_sx_end    = (r_phase == PH_SYSEX) && (i_byte == SYSEX_END);
    assign run_one_byte = (r_run_status == PGM_NIBBLE) || (r_run_status == PRESS_NIBBLE);
    assign hi_one_byte  = (hi == PGM_NIBBLE) || (hi == PRESS_NIBBLE);
    assign clk_sum      = {1'b0, r_clk_count} + 17'd1;
    assign sx_count_inc = (r_sx_count < MAX_SYSEX) ? r_sx_count + 13'd1 : r_sx_count;

    // Header bytes sit at offsets one to six of the message
    assign hdr_we  = i_en && !is_rt && !is_status && (r_phase == PH_SYSEX)
                     && (r_sx_count < MAX_SYSEX) && (r_sx_count != '0)
                     && (r_sx_count <= SX_HDR_LAST);
    assign hdr_idx = 3'(r_sx_count - 13'd1);

    // Classification on the count that includes the closing byte
    assign mfg_match = (sx_count_inc > 13'd4)
                       && ({1'b0, r_sx_hdr[0]} == i_cfg.manufacturer_id[23:16])
                       && ({1'b0, r_sx_hdr[1]} == i_cfg.manufacturer_id[15:8])
                       && ({1'b0, r_sx_hdr[2]} == i_cfg.manufacturer_id[7:0]);
    assign native_ok = mfg_match && (sx_count_inc > 13'd7)
                       && (r_sx_hdr[3] == i_cfg.product_id)
                       && ((r_sx_hdr[4] == BROADCAST_ID) || (r_sx_hdr[4] == i_cfg.device_id));
    assign universal_ok = !mfg_match && (sx_count_inc > 13'd2)
                          && (r_sx_hdr[0] == UNIVERSAL_NRT);

    // Next state
    always_comb begin
        n_phase      = r_phase;
        n_run_status = r_run_status;
        n_run_chan   = r_run_chan;
        n_held       = r_held;
        n_sx_count   = r_sx_count;
        n_armed      = r_armed;
        n_clk_count  = r_clk_count;
        if (i_en) begin
            priority if (is_rt) begin
                if (i_byte[3:0] == RT_START) begin
                    n_armed = 1'b1;
                end else if (i_byte[3:0] == RT_CLOCK) begin
                    if (r_armed) begin
                        n_armed     = 1'b0;
                        n_clk_count = '0;
                    end else if (clk_sum >= {1'b0, i_cfg.clock_wrap}) begin
                        n_clk_count = '0;
                    end else begin
                        n_clk_count = clk_sum[15:0];
                    end
                end
            end else if (is_sx_end) begin
                n_sx_count = sx_count_inc;
                n_phase    = PH_IDLE;
            end else if (is_status) begin
                // A status byte drops whatever message is pending
                if (hi == SYS_NIBBLE) begin
                    n_run_status = '0;
                    n_run_chan   = '0;
                    if (i_byte == SYSEX_START) begin
                        n_phase    = PH_SYSEX;
                        n_sx_count = 13'd1;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end else begin
                    n_run_status = hi;
                    n_run_chan   = i_byte[3:0];
                    n_phase      = hi_one_byte ? PH_ONE_OF_ONE : PH_ONE_OF_TWO;
                end
            end else if (r_phase == PH_SYSEX) begin
                n_sx_count = sx_count_inc;
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if ((r_run_status != '0) && !run_one_byte) begin
                            n_held  = i_byte[6:0];
                            n_phase = PH_SECOND;
                        end
                    end
                    PH_ONE_OF_ONE: n_phase = PH_IDLE;
                    PH_ONE_OF_TWO: begin
                        n_held  = i_byte[6:0];
                        n_phase = PH_SECOND;
                    end
                    PH_SECOND: n_phase = PH_IDLE;
                    default:   n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // Result
    always_comb begin
        o_emit                  = 1'b0;
        o_result                = '0;
        o_result.clock_position = n_clk_count;
        priority if (is_rt) begin
            o_emit           = 1'b1;
            o_result.kind    = KIND_RT;
            o_result.status  = SYSEX_START;
            o_result.channel = i_byte[3:0];
        end else if (is_sx_end) begin
            o_emit                = native_ok || universal_ok;
            o_result.kind         = native_ok ? KIND_NATIVE : KIND_UNIVERSAL;
            o_result.status       = SYSEX_START;
            o_result.sysex_length = sx_count_inc;
            o_result.sysex_command = native_ok ? r_sx_hdr[5] : 7'd0;
        end else if (!is_status && (r_phase != PH_SYSEX)) begin
            o_result.kind    = KIND_CHAN;
            o_result.status  = {r_run_status, 4'h0};
            o_result.channel = r_run_chan;
            if (r_phase == PH_SECOND) begin
                o_emit               = 1'b1;
                o_result.data_first  = r_held;
                o_result.data_second = i_byte[6:0];
            end else if ((r_phase == PH_ONE_OF_ONE)
                         || ((r_phase == PH_IDLE) && (r_run_status != '0) && run_one_byte)) begin
                o_emit              = 1'b1;
                o_result.data_first = i_byte[6:0];
            end
        end else begin
            o_emit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_run_status <= '0;
            r_run_chan   <= '0;
            r_held       <= '0;
            r_sx_count   <= '0;
            r_armed      <= 1'b0;
            r_clk_count  <= '0;
        end else begin
            r_phase      <= n_phase;
            r_run_status <= n_run_status;
            r_run_chan   <= n_run_chan;
            r_held       <= n_held;
            r_sx_count   <= n_sx_count;
            r_armed      <= n_armed;
            r_clk_count  <= n_clk_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            r_sx_hdr[hdr_idx] <= i_byte[6:0];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sx_count <= MAX_SYSEX)
        else $error("sysex count beyond saturation limit");

    a_run_status_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ONE_OF_ONE || r_phase == PH_ONE_OF_TWO || r_phase == PH_SECOND)
        |-> r_run_status[3])
        else $error("channel phase without running status");

    a_sysex_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SYSEX |-> r_run_status == '0)
        else $error("running status kept during sysex capture");

endmodule

[test/midi_input_parser_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_input_parser_test
// Self-checking bench for the MIDI input parser. A clocked driver feeds MIDI
// bytes from a queue, and a parser model in the bench predicts every message
// beat. A clocked monitor compares each beat field by field. Several register
// settings and flow-control modes are covered.
// ----------------------------------------------------------------------------
module midi_input_parser_test;
    import mip_pkg::*;

    localparam int N_PHASES = 6;
    localparam int BYTES_PER_PHASE = 240;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [7:0] RT_CLOCK_BYTE = {SYS_NIBBLE, RT_CLOCK};
    localparam logic [7:0] RT_START_BYTE = {SYS_NIBBLE, RT_START};
    localparam t_cfg CFG_DEFAULT = '{
        manufacturer_id: 24'h002127,
        product_id:      7'h5D,
        device_id:       7'h00,
        clock_wrap:      16'd384
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_MANUFACTURER;
    logic [23:0] i_cfg_data = 24'h0;

    midi_input_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // Stimulus and expectations
    logic [7:0] midi_tx_q[$];
    t_result    expected_msgs[$];
    logic [7:0] opening_seq [27];
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;
    int         queued_bytes = 0;
    int         accepted_bytes = 0;
    int         err_count = 0;
    int         kind_seen [4] = '{0, 0, 0, 0};

    // Parser model state
    t_cfg       model_cfg = CFG_DEFAULT;
    t_phase     parse_ph = PH_IDLE;
    logic [3:0] run_nibble = 4'h0;
    logic [3:0] run_chan = 4'h0;
    logic [6:0] held_first = 7'h0;
    int         sx_len = 0;
    logic [7:0] sx_hdr [6] = '{8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0};
    bit         clk_armed = 1'b0;
    logic [15:0] song_pos = 16'h0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("midi_input_parser test failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        err_count++;
    endtask

    function automatic t_phase data_phase(input logic [3:0] nibble);
        return (nibble == PGM_NIBBLE || nibble == PRESS_NIBBLE) ? PH_ONE_OF_ONE : PH_ONE_OF_TWO;
    endfunction

    // Advance the parser model by one byte; queue the message it completes.
    task automatic parse_midi_byte(input logic [7:0] b);
        t_result msg;
        bit      done;
        msg = '0;
        done = 1'b0;
        if (b >= RT_FIRST) begin
            if (b[3:0] == RT_START) begin
                clk_armed = 1'b1;
            end else if (b[3:0] == RT_CLOCK) begin
                if (clk_armed) begin
                    clk_armed = 1'b0;
                    song_pos = '0;
                end else if ({1'b0, song_pos} + 17'd1 >= {1'b0, model_cfg.clock_wrap}) begin
                    song_pos = '0;
                end else begin
                    song_pos = song_pos + 16'd1;
                end
            end
            msg.kind = KIND_RT;
            msg.status = {SYS_NIBBLE, 4'h0};
            msg.channel = b[3:0];
            done = 1'b1;
        end else if (parse_ph == PH_SYSEX && b == SYSEX_END) begin
            if (sx_len < MAX_SYSEX) sx_len++;
            parse_ph = PH_IDLE;
            if (sx_len > 4 && sx_hdr[0] == model_cfg.manufacturer_id[23:16]
                    && sx_hdr[1] == model_cfg.manufacturer_id[15:8]
                    && sx_hdr[2] == model_cfg.manufacturer_id[7:0]) begin
                // Manufacturer matched: native or nothing
                if (sx_len > 7 && sx_hdr[3] == {1'b0, model_cfg.product_id}
                        && (sx_hdr[4] == {1'b0, BROADCAST_ID}
                            || sx_hdr[4] == {1'b0, model_cfg.device_id})) begin
                    msg.kind = KIND_NATIVE;
                    msg.sysex_command = sx_hdr[5][6:0];
                    done = 1'b1;
                end
            end else if (sx_len > 2 && sx_hdr[0] == {1'b0, UNIVERSAL_NRT}) begin
                msg.kind = KIND_UNIVERSAL;
                done = 1'b1;
            end
            msg.status = {SYS_NIBBLE, 4'h0};
            msg.sysex_length = SX_LEN_W'(sx_len);
        end else if (b[7]) begin
            // Any status drops what is pending
            if (b[7:4] == SYS_NIBBLE) begin
                run_nibble = 4'h0;
                run_chan = 4'h0;
                if (b == SYSEX_START) begin
                    parse_ph = PH_SYSEX;
                    sx_len = 1;
                end else begin
                    parse_ph = PH_IDLE;
                end
            end else begin
                run_nibble = b[7:4];
                run_chan = b[3:0];
                parse_ph = data_phase(b[7:4]);
            end
        end else if (parse_ph == PH_SYSEX) begin
            if (sx_len < MAX_SYSEX) begin
                if (sx_len >= 1 && sx_len <= 6) sx_hdr[sx_len - 1] = b;
                sx_len++;
            end
        end else begin
            if (parse_ph == PH_IDLE && run_nibble != 4'h0) parse_ph = data_phase(run_nibble);
            msg.kind = KIND_CHAN;
            msg.status = {run_nibble, 4'h0};
            msg.channel = run_chan;
            case (parse_ph)
                PH_ONE_OF_ONE: begin
                    msg.data_first = b[6:0];
                    parse_ph = PH_IDLE;
                    done = 1'b1;
                end
                PH_ONE_OF_TWO: begin
                    held_first = b[6:0];
                    parse_ph = PH_SECOND;
                end
                PH_SECOND: begin
                    msg.data_first = held_first;
                    msg.data_second = b[6:0];
                    parse_ph = PH_IDLE;
                    done = 1'b1;
                end
                default: ;
            endcase
        end
        if (done) begin
            msg.clock_position = song_pos;
            expected_msgs.push_back(msg);
        end
    endtask

    task automatic compare_field(input string name, input int unsigned got,
                                 input int unsigned want);
        if (got != want) report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    task automatic check_message(input t_result got);
        t_result want;
        if (expected_msgs.size() == 0) begin
            report_mismatch($sformatf("unexpected beat: kind %0d status 0x%0h",
                                      got.kind, got.status));
            return;
        end
        want = expected_msgs.pop_front();
        compare_field("kind", 32'(got.kind), 32'(want.kind));
        compare_field("status", 32'(got.status), 32'(want.status));
        compare_field("channel", 32'(got.channel), 32'(want.channel));
        compare_field("data_first", 32'(got.data_first), 32'(want.data_first));
        compare_field("data_second", 32'(got.data_second), 32'(want.data_second));
        compare_field("sysex_command", 32'(got.sysex_command), 32'(want.sysex_command));
        compare_field("sysex_length", 32'(got.sysex_length), 32'(want.sysex_length));
        compare_field("clock_position", 32'(got.clock_position),
                      32'(want.clock_position));
    endtask

    // Driver: predict on each accepted beat, then load the next byte or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_midi_byte(s_axis_tdata);
                accepted_bytes++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (midi_tx_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= midi_tx_q.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: unpack and check each result beat, stall at random
    always @(posedge i_clk) begin
        t_result got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = m_axis_tuser;
                got.status = m_axis_tdata[7:0];
                got.channel = m_axis_tdata[11:8];
                got.data_first = m_axis_tdata[18:12];
                got.data_second = m_axis_tdata[25:19];
                got.sysex_command = m_axis_tdata[32:26];
                got.sysex_length = m_axis_tdata[45:33];
                got.clock_position = m_axis_tdata[61:46];
                kind_seen[got.kind]++;
                check_message(got);
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic logic [7:0] rand_data();
        return 8'($urandom_range(127));
    endfunction

    function automatic logic [7:0] rand_realtime();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5) return RT_CLOCK_BYTE;
        if (pick == 5) return RT_START_BYTE;
        return RT_FIRST | 8'($urandom_range(7));
    endfunction

    // Queue a byte, now and then with a real-time byte slipped in ahead
    task automatic queue_byte(input logic [7:0] b);
        if ($urandom_range(99) < 8) begin
            midi_tx_q.push_back(rand_realtime());
            queued_bytes++;
        end
        midi_tx_q.push_back(b);
        queued_bytes++;
    endtask

    task automatic queue_sysex(input bit native);
        logic [7:0] body[$];
        logic [7:0] b;
        int cut;
        int pick;
        body.push_back(SYSEX_START);
        if (native) begin
            for (int k = 2; k >= 0; k--) begin
                b = model_cfg.manufacturer_id[8*k +: 8];
                body.push_back(b[7] ? rand_data() : b);
            end
            body.push_back($urandom_range(99) < 80 ? {1'b0, model_cfg.product_id} : rand_data());
            pick = $urandom_range(99);
            if (pick < 50) body.push_back({1'b0, model_cfg.device_id});
            else if (pick < 80) body.push_back({1'b0, BROADCAST_ID});
            else body.push_back(rand_data());
            body.push_back(rand_data());
        end else begin
            body.push_back($urandom_range(99) < 80 ? {1'b0, UNIVERSAL_NRT} : rand_data());
        end
        repeat ($urandom_range(6)) body.push_back(rand_data());
        cut = body.size();
        if ($urandom_range(99) < 20) cut = $urandom_range(body.size() - 1, 1);
        for (int k = 0; k < cut; k++) queue_byte(body[k]);
        // Mostly close properly; otherwise abort with another status
        if ($urandom_range(99) < 85) queue_byte(SYSEX_END);
        else queue_byte(8'($urandom_range(8'hF6, 8'h80)));
    endtask

    task automatic queue_traffic(input int count);
        logic [7:0] st;
        int goal;
        int pick;
        int n_data;
        goal = queued_bytes + count;
        while (queued_bytes < goal) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                st = 8'($urandom_range(8'hEF, 8'h80));
                n_data = (data_phase(st[7:4]) == PH_ONE_OF_ONE) ? 1 : 2;
                queue_byte(st);
                // Extra rounds ride on running status
                repeat ($urandom_range(3, 1)) repeat (n_data) queue_byte(rand_data());
            end else if (pick < 48) begin
                if ($urandom_range(99) < 30) queue_byte(RT_START_BYTE);
                repeat ($urandom_range(12, 1)) queue_byte(RT_CLOCK_BYTE);
            end else if (pick < 68) begin
                queue_sysex(1'b1);
            end else if (pick < 78) begin
                queue_sysex(1'b0);
            end else if (pick < 90) begin
                // Broken message: truncated, then system common or stray data
                queue_byte(8'($urandom_range(8'hEF, 8'h80)));
                if ($urandom_range(1)) queue_byte(rand_data());
                if ($urandom_range(1)) queue_byte(8'($urandom_range(8'hF7, 8'hF1)));
                else queue_byte(rand_data());
            end else begin
                repeat ($urandom_range(4, 1)) queue_byte(8'($urandom_range(255)));
            end
        end
    endtask

    // Wait for all bytes in and all messages out, then let the pipe settle
    task automatic drain_pipeline();
        int waited;
        waited = 0;
        while ((midi_tx_q.size() != 0 || s_axis_tvalid || expected_msgs.size() != 0)
               && waited < 200000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (expected_msgs.size() != 0) begin
            report_mismatch($sformatf("%0d expected beats never arrived",
                                      expected_msgs.size()));
            expected_msgs.delete();
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input t_cfg c);
        write_reg(CFG_MANUFACTURER, c.manufacturer_id);
        write_reg(CFG_PRODUCT, {17'h0, c.product_id});
        write_reg(CFG_DEVICE, {17'h0, c.device_id});
        write_reg(CFG_CLOCK_WRAP, {8'h0, c.clock_wrap});
        model_cfg = c;
    endtask

    function automatic t_cfg setting_for(input int phase);
        t_cfg c;
        c.manufacturer_id = {1'b0, 7'($urandom_range(127)), 1'b0, 7'($urandom_range(127)),
                             1'b0, 7'($urandom_range(127))};
        c.product_id = 7'($urandom_range(127));
        c.device_id = 7'($urandom_range(127));
        c.clock_wrap = 16'($urandom_range(24, 2));
        case (phase)
            1: c = '{24'hFFFFFF, 7'h7F, 7'h7F, 16'd1};
            2: c = '{24'h000000, 7'h00, 7'h00, 16'hFFFF};
            4: begin
                // Manufacturer id that begins like a universal message
                c.manufacturer_id[23:16] = {1'b0, UNIVERSAL_NRT};
                c.clock_wrap = 16'($urandom_range(6, 1));
            end
            5: begin
                c.manufacturer_id = 24'($urandom_range(24'hFFFFFF));
                c.clock_wrap = 16'($urandom_range(40, 1));
            end
            default: ;
        endcase
        return c;
    endfunction

    initial begin
        opening_seq = '{
            8'h35,
            8'h90, 8'h00, 8'h7F,
            8'h7F, 8'h00,
            8'hC5, 8'h12,
            RT_START_BYTE, RT_CLOCK_BYTE, RT_CLOCK_BYTE, 8'hFF,
            8'hE0, 8'h01,
            SYSEX_START, 8'h00, 8'h21, 8'h27, 8'h5D, {1'b0, BROADCAST_ID}, 8'h42, SYSEX_END,
            SYSEX_START, {1'b0, UNIVERSAL_NRT}, SYSEX_END,
            8'hF3, 8'h11
        };
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 83; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 83; end
                default: begin src_idle_pct = 30; sink_stall_pct = 30; end
            endcase
            if (phase == 0) begin
                // Defaults after reset, starting with the hand-picked bytes
                foreach (opening_seq[k]) begin
                    midi_tx_q.push_back(opening_seq[k]);
                    queued_bytes++;
                end
            end else begin
                apply_setting(setting_for(phase));
            end
            queue_traffic(BYTES_PER_PHASE);
            drain_pipeline();
        end

        $display("Covered %0d MIDI bytes over %0d register settings and four flow-control modes.",
                 accepted_bytes, N_PHASES);
        $display("Checked %0d channel, %0d real-time, %0d native and %0d universal sysex beats.",
                 kind_seen[KIND_CHAN], kind_seen[KIND_RT], kind_seen[KIND_NATIVE],
                 kind_seen[KIND_UNIVERSAL]);
        if (err_count == 0) begin
            $display("midi_input_parser test passed");
        end else begin
            $display("midi_input_parser test failed");
        end
        $finish;
    end

endmodule

[midi_input_parser.f]
hdl/mip_pkg.sv
hdl/mip_parser.sv
hdl/midi_input_parser.sv
test/midi_input_parser_test.sv
